[sv/biased_lattice_walk_with_running_mean_macros.svh]
// Assertion macros for the biased lattice walk block.
// Used by the top level only; relies on signals named clk and rst in scope.
`ifndef BIASED_LATTICE_WALK_WITH_RUNNING_MEAN_MACROS_SVH
`define BIASED_LATTICE_WALK_WITH_RUNNING_MEAN_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define BLW_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define BLW_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

[sv/blw_pkg.sv]
// Shared types and constants of the biased lattice walk block.
// No dependencies; used by every module of the block.
package blw_pkg;

  // Fixed field widths of the streams and the configuration port.
  localparam int FRACTION_W  = 32;
  localparam int CUT_W       = 33;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 33;
  localparam int REG_SIZE_W  = 16;
  localparam int INTERVAL_W  = 32;
  localparam int SUM_W       = 64;
  localparam int JUMP_W      = 32;
  localparam int MEAN_W      = 49;
  localparam int MEAN_MAG_W  = 48;
  localparam int X_W         = 33;
  localparam int POS_W       = 16;
  localparam int OUT_FIELDS_W = JUMP_W + MEAN_W + X_W + 2 * POS_W;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Reset values of the configuration registers.
  localparam logic [CUT_W-1:0] CUT_PLUS_X_RESET  = 33'd719412992;
  localparam logic [CUT_W-1:0] CUT_MINUS_X_RESET = 33'd1431667705;
  localparam logic [CUT_W-1:0] CUT_PLUS_Y_RESET  = 33'd2147492582;
  localparam logic [CUT_W-1:0] CUT_MINUS_Y_RESET = 33'd2863317458;
  localparam logic [CUT_W-1:0] CUT_PLUS_Z_RESET  = 33'd3579142377;
  localparam logic [REG_SIZE_W-1:0] WIDTH_Y_RESET  = 16'd100;
  localparam logic [REG_SIZE_W-1:0] HEIGHT_Z_RESET = 16'd100;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd1000;

  // Record queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CUT_PLUS_X  = 3'd0,
    REG_CUT_MINUS_X = 3'd1,
    REG_CUT_PLUS_Y  = 3'd2,
    REG_CUT_MINUS_Y = 3'd3,
    REG_CUT_PLUS_Z  = 3'd4,
    REG_WIDTH_Y     = 3'd5,
    REG_HEIGHT_Z    = 3'd6,
    REG_INTERVAL    = 3'd7
  } cfg_reg_t;

  // Lattice move chosen from the random fraction.
  typedef enum logic [2:0] {
    MOVE_PX = 3'd0,
    MOVE_MX = 3'd1,
    MOVE_PY = 3'd2,
    MOVE_MY = 3'd3,
    MOVE_PZ = 3'd4,
    MOVE_MZ = 3'd5
  } move_t;

  // Front state machine.
  typedef enum logic [1:0] {
    FR_RUN = 2'b01,
    FR_MOD = 2'b10
  } front_state_t;

  // Back state machine.
  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_SEND = 3'b100
  } back_state_t;

  // Which records a queued snapshot calls for.
  typedef struct packed {
    logic due;
    logic last;
  } rec_flags_t;

  // Fill status of the record queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/blw_fifo.sv]
// Two-entry record queue between the front and back parts.
// Depends on blw_pkg for the queue depth and status struct.
module blw_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output blw_pkg::q_status_t    status
);

  logic [WIDTH-1:0]                 entries [blw_pkg::QUEUE_DEPTH];
  logic [blw_pkg::QPTR_W-1:0]       wr_ptr;
  logic [blw_pkg::QPTR_W-1:0]       rd_ptr;
  logic [blw_pkg::QCNT_W-1:0]       count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + blw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + blw_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + blw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - blw_pkg::QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign pop_data     = entries[rd_ptr];
  assign status.full  = (count == blw_pkg::QCNT_W'(blw_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

[sv/blw_front.sv]
// Front part: configuration registers, move choice and walker state update.
// Depends on blw_pkg; feeds record snapshots into blw_fifo.
module blw_front #(
  parameter int JUMP_COUNT_BITS = 32,
  parameter int SIZE_BITS       = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [blw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [blw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [blw_pkg::FRACTION_W-1:0]     in_fraction,
  input  logic                               in_last,
  input  blw_pkg::q_status_t                 q_status,
  output logic                               q_push,
  output blw_pkg::rec_flags_t                q_flags,
  output logic [JUMP_COUNT_BITS-1:0]         q_jumps,
  output logic signed [blw_pkg::SUM_W-1:0]   q_sum,
  output logic signed [JUMP_COUNT_BITS:0]    q_x,
  output logic [SIZE_BITS-1:0]               q_y,
  output logic [SIZE_BITS-1:0]               q_z
);

  localparam int MC_W = $clog2(SIZE_BITS);
  localparam logic signed [JUMP_COUNT_BITS:0] X_MAX = {1'b0, {JUMP_COUNT_BITS{1'b1}}};
  localparam logic signed [JUMP_COUNT_BITS:0] X_MIN =
    {1'b1, {(JUMP_COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic signed [blw_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(blw_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [blw_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(blw_pkg::SUM_W-1){1'b0}}};
  localparam logic [SIZE_BITS:0] FULL_SIZE = {1'b1, {SIZE_BITS{1'b0}}};
  localparam logic [SIZE_BITS-1:0] RST_Y_LOW = blw_pkg::WIDTH_Y_RESET[SIZE_BITS-1:0];
  localparam logic [SIZE_BITS-1:0] RST_Z_LOW = blw_pkg::HEIGHT_Z_RESET[SIZE_BITS-1:0];
  localparam logic [SIZE_BITS:0] RST_SIZE_Y =
    (RST_Y_LOW == '0) ? FULL_SIZE : {1'b0, RST_Y_LOW};
  localparam logic [SIZE_BITS:0] RST_SIZE_Z =
    (RST_Z_LOW == '0) ? FULL_SIZE : {1'b0, RST_Z_LOW};

  // Configuration registers.
  logic [blw_pkg::CUT_W-1:0]      cut_plus_x, cut_minus_x, cut_plus_y;
  logic [blw_pkg::CUT_W-1:0]      cut_minus_y, cut_plus_z;
  logic [blw_pkg::REG_SIZE_W-1:0] width_y, height_z;
  logic [blw_pkg::INTERVAL_W-1:0] measure_interval;

  // Walker state.
  blw_pkg::front_state_t              state, state_next;
  logic signed [JUMP_COUNT_BITS:0]    x_coord, x_coord_next, x_step;
  logic [SIZE_BITS-1:0]               y_coord, y_coord_next;
  logic [SIZE_BITS-1:0]               z_coord, z_coord_next;
  logic [JUMP_COUNT_BITS-1:0]         jump_total, jump_total_next, jump_inc;
  logic signed [blw_pkg::SUM_W-1:0]   x_sum, x_sum_next, sum_add, sum_sat, x_wide;
  logic                               sum_ovf;
  logic [blw_pkg::INTERVAL_W-1:0]     interval_count, interval_count_next;
  logic [blw_pkg::INTERVAL_W-1:0]     interval_m1;
  logic                               due;

  // Slow wrap unit for a coordinate that lies beyond a shrunken size.
  logic [SIZE_BITS:0]                 mod_rem, mod_size, rem_shift, rem_red;
  logic [SIZE_BITS-1:0]               mod_src;
  logic [MC_W-1:0]                    mod_cnt;
  logic                               mod_up, mod_is_z;
  blw_pkg::rec_flags_t                mod_flags;
  logic                               mod_start;

  logic [SIZE_BITS:0]                 size_y, size_z;
  logic [blw_pkg::CUT_W-1:0]          frac_ext;
  blw_pkg::move_t                     move;
  logic                               accept;
  logic                               y_in_range, z_in_range;

  // Step a coordinate by one within [0, m), the coordinate already below m.
  function automatic logic [SIZE_BITS-1:0] wrap_step(input logic [SIZE_BITS:0] c,
                                                      input logic [SIZE_BITS:0] m,
                                                      input logic up);
    logic [SIZE_BITS:0] r;
    if (up) begin
      r = ((c + (SIZE_BITS+1)'(1)) == m) ? '0 : c + (SIZE_BITS+1)'(1);
    end else begin
      r = (c == '0) ? m - (SIZE_BITS+1)'(1) : c - (SIZE_BITS+1)'(1);
    end
    return r[SIZE_BITS-1:0];
  endfunction

  // Effective sizes; a zero register acts as the full range.
  assign size_y = (width_y[SIZE_BITS-1:0] == '0) ? FULL_SIZE : {1'b0, width_y[SIZE_BITS-1:0]};
  assign size_z = (height_z[SIZE_BITS-1:0] == '0) ? FULL_SIZE : {1'b0, height_z[SIZE_BITS-1:0]};
  assign y_in_range = ({1'b0, y_coord} < size_y);
  assign z_in_range = ({1'b0, z_coord} < size_z);

  assign in_ready = (state == blw_pkg::FR_RUN) && !q_status.full;
  assign accept   = in_valid && in_ready;

  // Move choice: the first threshold above the fraction wins.
  assign frac_ext = blw_pkg::CUT_W'(in_fraction);
  always_comb begin
    if (frac_ext < cut_plus_x) begin
      move = blw_pkg::MOVE_PX;
    end else if (frac_ext < cut_minus_x) begin
      move = blw_pkg::MOVE_MX;
    end else if (frac_ext < cut_plus_y) begin
      move = blw_pkg::MOVE_PY;
    end else if (frac_ext < cut_minus_y) begin
      move = blw_pkg::MOVE_MY;
    end else if (frac_ext < cut_plus_z) begin
      move = blw_pkg::MOVE_PZ;
    end else begin
      move = blw_pkg::MOVE_MZ;
    end
  end

  // Saturating x move.
  always_comb begin
    x_step = x_coord;
    if (move == blw_pkg::MOVE_PX && x_coord != X_MAX) begin
      x_step = x_coord + (JUMP_COUNT_BITS+1)'(1);
    end else if (move == blw_pkg::MOVE_MX && x_coord != X_MIN) begin
      x_step = x_coord - (JUMP_COUNT_BITS+1)'(1);
    end
  end

  // Saturating sum of x positions, jump count and interval count.
  assign x_wide   = blw_pkg::SUM_W'(x_step);
  assign sum_add  = x_sum + x_wide;
  assign sum_ovf  = (x_sum[blw_pkg::SUM_W-1] == x_wide[blw_pkg::SUM_W-1]) &&
                    (sum_add[blw_pkg::SUM_W-1] != x_sum[blw_pkg::SUM_W-1]);
  assign sum_sat  = sum_ovf ? (x_wide[blw_pkg::SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_add;
  assign jump_inc = (jump_total == '1) ? jump_total
                                       : jump_total + JUMP_COUNT_BITS'(1);
  assign interval_m1 = (measure_interval == '0) ? '0
                                                : measure_interval - blw_pkg::INTERVAL_W'(1);
  assign due = (interval_count >= interval_m1);

  // Remainder step of the slow wrap unit.
  assign rem_shift = {mod_rem[SIZE_BITS-1:0], mod_src[SIZE_BITS-1]};
  assign rem_red   = (rem_shift >= mod_size) ? rem_shift - mod_size : rem_shift;

  // Next state of the walker and queue push.
  always_comb begin
    state_next          = state;
    x_coord_next        = x_coord;
    y_coord_next        = y_coord;
    z_coord_next        = z_coord;
    jump_total_next     = jump_total;
    x_sum_next          = x_sum;
    interval_count_next = interval_count;
    q_push              = 1'b0;
    q_flags             = '0;
    mod_start           = 1'b0;
    unique case (state)
      blw_pkg::FR_RUN: begin
        if (accept) begin
          if (in_action) begin
            x_coord_next        = '0;
            y_coord_next        = size_y[SIZE_BITS:1];
            z_coord_next        = size_z[SIZE_BITS:1];
            jump_total_next     = '0;
            x_sum_next          = '0;
            interval_count_next = '0;
          end else begin
            x_coord_next        = x_step;
            jump_total_next     = jump_inc;
            x_sum_next          = sum_sat;
            interval_count_next = due ? '0 : interval_count + blw_pkg::INTERVAL_W'(1);
            unique case (move) inside
              blw_pkg::MOVE_PY, blw_pkg::MOVE_MY: begin
                if (y_in_range) begin
                  y_coord_next = wrap_step({1'b0, y_coord}, size_y,
                                           move == blw_pkg::MOVE_PY);
                end else begin
                  mod_start = 1'b1;
                end
              end
              blw_pkg::MOVE_PZ, blw_pkg::MOVE_MZ: begin
                if (z_in_range) begin
                  z_coord_next = wrap_step({1'b0, z_coord}, size_z,
                                           move == blw_pkg::MOVE_PZ);
                end else begin
                  mod_start = 1'b1;
                end
              end
              default: begin
              end
            endcase
            if (mod_start) begin
              state_next = blw_pkg::FR_MOD;
            end else begin
              q_push       = due || in_last;
              q_flags.due  = due;
              q_flags.last = in_last;
            end
          end
        end
      end
      blw_pkg::FR_MOD: begin
        if (mod_cnt == '0) begin
          state_next = blw_pkg::FR_RUN;
          if (mod_is_z) begin
            z_coord_next = wrap_step(rem_red, mod_size, mod_up);
          end else begin
            y_coord_next = wrap_step(rem_red, mod_size, mod_up);
          end
          q_push  = mod_flags.due || mod_flags.last;
          q_flags = mod_flags;
        end
      end
      default: begin
        state_next = blw_pkg::FR_RUN;
      end
    endcase
  end

  // Snapshot handed to the queue is the state after this item.
  assign q_jumps = jump_total_next;
  assign q_sum   = x_sum_next;
  assign q_x     = x_coord_next;
  assign q_y     = y_coord_next;
  assign q_z     = z_coord_next;

  // Configuration and walker state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cut_plus_x       <= blw_pkg::CUT_PLUS_X_RESET;
      cut_minus_x      <= blw_pkg::CUT_MINUS_X_RESET;
      cut_plus_y       <= blw_pkg::CUT_PLUS_Y_RESET;
      cut_minus_y      <= blw_pkg::CUT_MINUS_Y_RESET;
      cut_plus_z       <= blw_pkg::CUT_PLUS_Z_RESET;
      width_y          <= blw_pkg::WIDTH_Y_RESET;
      height_z         <= blw_pkg::HEIGHT_Z_RESET;
      measure_interval <= blw_pkg::INTERVAL_RESET;
      state            <= blw_pkg::FR_RUN;
      x_coord          <= '0;
      y_coord          <= RST_SIZE_Y[SIZE_BITS:1];
      z_coord          <= RST_SIZE_Z[SIZE_BITS:1];
      jump_total       <= '0;
      x_sum            <= '0;
      interval_count   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (blw_pkg::cfg_reg_t'(cfg_index))
          blw_pkg::REG_CUT_PLUS_X:  cut_plus_x  <= cfg_data;
          blw_pkg::REG_CUT_MINUS_X: cut_minus_x <= cfg_data;
          blw_pkg::REG_CUT_PLUS_Y:  cut_plus_y  <= cfg_data;
          blw_pkg::REG_CUT_MINUS_Y: cut_minus_y <= cfg_data;
          blw_pkg::REG_CUT_PLUS_Z:  cut_plus_z  <= cfg_data;
          blw_pkg::REG_WIDTH_Y:     width_y     <= cfg_data[blw_pkg::REG_SIZE_W-1:0];
          blw_pkg::REG_HEIGHT_Z:    height_z    <= cfg_data[blw_pkg::REG_SIZE_W-1:0];
          blw_pkg::REG_INTERVAL:    measure_interval <= cfg_data[blw_pkg::INTERVAL_W-1:0];
          default: begin
          end
        endcase
      end
      state          <= state_next;
      x_coord        <= x_coord_next;
      y_coord        <= y_coord_next;
      z_coord        <= z_coord_next;
      jump_total     <= jump_total_next;
      x_sum          <= x_sum_next;
      interval_count <= interval_count_next;
    end
  end

  // Slow wrap unit: restoring remainder, one coordinate bit a cycle.
  always_ff @(posedge clk) begin
    if (mod_start) begin
      mod_rem   <= '0;
      mod_cnt   <= MC_W'(SIZE_BITS - 1);
      mod_up    <= (move == blw_pkg::MOVE_PY) || (move == blw_pkg::MOVE_PZ);
      mod_is_z  <= (move == blw_pkg::MOVE_PZ) || (move == blw_pkg::MOVE_MZ);
      mod_flags <= '{due: due, last: in_last};
      if ((move == blw_pkg::MOVE_PZ) || (move == blw_pkg::MOVE_MZ)) begin
        mod_src  <= z_coord;
        mod_size <= size_z;
      end else begin
        mod_src  <= y_coord;
        mod_size <= size_y;
      end
    end else if (state == blw_pkg::FR_MOD) begin
      mod_rem <= rem_red;
      mod_src <= {mod_src[SIZE_BITS-2:0], 1'b0};
      mod_cnt <= mod_cnt - MC_W'(1);
    end
  end

endmodule

[sv/blw_mean_div.sv]
// Restoring divider for the running mean: |sum| * 2^F / jumps, one bit a cycle.
// Depends on blw_pkg for the sum and mean widths; used by blw_back.
module blw_mean_div #(
  parameter int JUMP_COUNT_BITS    = 32,
  parameter int MEAN_FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [blw_pkg::SUM_W-1:0]  sum_in,
  input  logic [JUMP_COUNT_BITS-1:0]        count_in,
  output logic                              done,
  output logic [blw_pkg::MEAN_W-1:0]        mean
);

  localparam int DVD_W = blw_pkg::SUM_W + MEAN_FRACTION_BITS;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [blw_pkg::MEAN_MAG_W-1:0] MEAN_MAX = '1;

  logic [DVD_W-1:0]                   dividend;
  logic [JUMP_COUNT_BITS-1:0]         divisor;
  logic [JUMP_COUNT_BITS-1:0]         rem;
  logic [JUMP_COUNT_BITS:0]           rem_shift, rem_next;
  logic                               q_bit;
  logic [blw_pkg::MEAN_MAG_W-1:0]     quo;
  logic [blw_pkg::MEAN_MAG_W-1:0]     mag_q;
  logic                               ovf;
  logic                               neg;
  logic                               busy;
  logic [CNT_W-1:0]                   cnt;
  logic [blw_pkg::SUM_W-1:0]          mag;

  assign mag = sum_in[blw_pkg::SUM_W-1] ? blw_pkg::SUM_W'(0) - sum_in : sum_in;

  // One restoring step.
  assign rem_shift = {rem, dividend[DVD_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor});
  assign rem_next  = q_bit ? rem_shift - {1'b0, divisor} : rem_shift;

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath; quotient bits above the mean range set a sticky overflow.
  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= DVD_W'(mag) << MEAN_FRACTION_BITS;
      divisor  <= count_in;
      rem      <= '0;
      quo      <= '0;
      ovf      <= 1'b0;
      neg      <= sum_in[blw_pkg::SUM_W-1];
      cnt      <= CNT_W'(DVD_W - 1);
    end else if (busy) begin
      dividend <= {dividend[DVD_W-2:0], 1'b0};
      rem      <= rem_next[JUMP_COUNT_BITS-1:0];
      quo      <= {quo[blw_pkg::MEAN_MAG_W-2:0], q_bit};
      ovf      <= ovf | quo[blw_pkg::MEAN_MAG_W-1];
      cnt      <= cnt - CNT_W'(1);
    end
  end

  // Saturate and restore the sign.
  assign mag_q = ovf ? MEAN_MAX : quo;
  assign mean  = neg ? blw_pkg::MEAN_W'(0) - {1'b0, mag_q} : {1'b0, mag_q};

endmodule

[sv/blw_back.sv]
// Back part: takes record snapshots from the queue, runs the mean division
// and sends the interval and final records. Depends on blw_pkg and blw_mean_div.
module blw_back #(
  parameter int JUMP_COUNT_BITS    = 32,
  parameter int SIZE_BITS          = 16,
  parameter int MEAN_FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  blw_pkg::q_status_t                 q_status,
  output logic                               q_pop,
  input  blw_pkg::rec_flags_t                q_flags,
  input  logic [JUMP_COUNT_BITS-1:0]         q_jumps,
  input  logic signed [blw_pkg::SUM_W-1:0]   q_sum,
  input  logic signed [JUMP_COUNT_BITS:0]    q_x,
  input  logic [SIZE_BITS-1:0]               q_y,
  input  logic [SIZE_BITS-1:0]               q_z,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [blw_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast
);

  blw_pkg::back_state_t            state, state_next;
  logic                            sent_ivl, sent_ivl_next;
  logic                            div_start, div_done;
  logic [blw_pkg::MEAN_W-1:0]      div_mean;
  logic                            out_load;
  logic                            rec_final, rec_last;
  logic [blw_pkg::OUT_FIELDS_W-1:0] rec_fields;

  blw_mean_div #(
    .JUMP_COUNT_BITS    (JUMP_COUNT_BITS),
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum_in   (q_sum),
    .count_in (q_jumps),
    .done     (div_done),
    .mean     (div_mean)
  );

  // Sequencer: the queue head stays in place until its last record is sent.
  always_comb begin
    state_next    = state;
    sent_ivl_next = sent_ivl;
    div_start     = 1'b0;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    rec_final     = 1'b0;
    rec_last      = 1'b0;
    unique case (state)
      blw_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          div_start     = 1'b1;
          sent_ivl_next = 1'b0;
          state_next    = blw_pkg::BK_DIV;
        end
      end
      blw_pkg::BK_DIV: begin
        if (div_done) begin
          state_next = blw_pkg::BK_SEND;
        end
      end
      blw_pkg::BK_SEND: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          if (q_flags.due && !sent_ivl) begin
            rec_final = 1'b0;
            rec_last  = !q_flags.last;
            if (q_flags.last) begin
              sent_ivl_next = 1'b1;
            end else begin
              q_pop      = 1'b1;
              state_next = blw_pkg::BK_IDLE;
            end
          end else begin
            rec_final  = 1'b1;
            rec_last   = 1'b1;
            q_pop      = 1'b1;
            state_next = blw_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = blw_pkg::BK_IDLE;
      end
    endcase
  end

  // Record layout from the lowest bit: jumps, mean, x, y, z.
  assign rec_fields = {blw_pkg::POS_W'(q_z),
                       blw_pkg::POS_W'(q_y),
                       blw_pkg::X_W'(q_x),
                       div_mean,
                       blw_pkg::JUMP_W'(q_jumps)};

  // State and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= blw_pkg::BK_IDLE;
      sent_ivl <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      sent_ivl <= sent_ivl_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= blw_pkg::OUT_DATA_W'(rec_fields);
      m_tuser <= rec_final;
      m_tlast <= rec_last;
    end
  end

endmodule

[sv/biased_lattice_walk_with_running_mean.sv]
// Top level of the biased lattice walk with running mean of x.
// Depends on blw_pkg, blw_front, blw_fifo, blw_back and the macros header.
//
// A jump item is taken by the front part, which picks the move from five
// thresholds and updates the position, jump count and saturating sum of x in
// the cycle it is taken; a y or z move from a coordinate at or beyond a size
// written since the last restart is finished in the front's bit-serial
// remainder unit. A jump that is due for a record puts a snapshot into a
// two-entry queue; the back part turns each snapshot into one or two records,
// running its restoring divider for the mean before sending them. Apart from
// a run of the remainder unit, the front stops taking items only while both
// queue entries are held, so jumps go in at one per cycle as long as records
// are due no more often than once per divider run and the receiver keeps up.
// Restart items give no record. Configuration writes are always taken.
`include "biased_lattice_walk_with_running_mean_macros.svh"

module biased_lattice_walk_with_running_mean #(
  parameter int JUMP_COUNT_BITS    = 32,
  parameter int SIZE_BITS          = 16,
  parameter int MEAN_FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [blw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [blw_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input items.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [blw_pkg::FRACTION_W-1:0]     s_tdata,   // random_fraction[31:0]
  input  logic                               s_tuser,   // action
  input  logic                               s_tlast,   // is_last
  // Result items.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // jumps[31:0], mean_x_q16[80:32], x_coord[113:81],
  // y_position[129:114], z_position[145:130], zero padding above
  output logic [blw_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tuser,   // is_final
  output logic                               m_tlast    // last_of_run
);

  localparam int Q_W = $bits(blw_pkg::rec_flags_t) + JUMP_COUNT_BITS + blw_pkg::SUM_W +
                       (JUMP_COUNT_BITS + 1) + 2 * SIZE_BITS;

  blw_pkg::q_status_t                 q_status;
  logic                               q_push, q_pop;
  logic [Q_W-1:0]                     q_push_data, q_pop_data;
  blw_pkg::rec_flags_t                push_flags, pop_flags;
  logic [JUMP_COUNT_BITS-1:0]         push_jumps, pop_jumps;
  logic signed [blw_pkg::SUM_W-1:0]   push_sum, pop_sum;
  logic signed [JUMP_COUNT_BITS:0]    push_x, pop_x;
  logic [SIZE_BITS-1:0]               push_y, pop_y, push_z, pop_z;

  assign cfg_ready = 1'b1;

  // Front part: classify and update the walker.
  blw_front #(
    .JUMP_COUNT_BITS (JUMP_COUNT_BITS),
    .SIZE_BITS       (SIZE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_action   (s_tuser),
    .in_fraction (s_tdata),
    .in_last     (s_tlast),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_flags     (push_flags),
    .q_jumps     (push_jumps),
    .q_sum       (push_sum),
    .q_x         (push_x),
    .q_y         (push_y),
    .q_z         (push_z)
  );

  // Record queue.
  assign q_push_data = {push_flags, push_jumps, push_sum, push_x, push_y, push_z};

  blw_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  assign {pop_flags, pop_jumps, pop_sum, pop_x, pop_y, pop_z} = q_pop_data;

  // Back part: mean division and record output.
  blw_back #(
    .JUMP_COUNT_BITS    (JUMP_COUNT_BITS),
    .SIZE_BITS          (SIZE_BITS),
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_pop    (q_pop),
    .q_flags  (pop_flags),
    .q_jumps  (pop_jumps),
    .q_sum    (pop_sum),
    .q_x      (pop_x),
    .q_y      (pop_y),
    .q_z      (pop_z),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Checks on the queue between the two parts.
  `BLW_ASSERT_NOW(a_push_not_full, q_push, !q_status.full, "record pushed into a full queue")
  `BLW_ASSERT_NOW(a_pop_not_empty, q_pop, !q_status.empty, "record popped from an empty queue")
  `BLW_ASSERT_NOW(a_ready_has_room, s_tvalid && s_tready, !q_status.full, "item taken with queue full")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the biased lattice walk with running mean of x.
// Depends on blw_pkg and biased_lattice_walk_with_running_mean; reads no files.
// A queue-fed driver and a monitor check every record against a built-in walk predictor.

module tb_top;

  localparam int JUMP_BITS = 32;
  localparam int SIZE_BITS_TB = 16;
  localparam int FRAC_BITS = 16;
  localparam longint X_LIMIT = (longint'(1) << JUMP_BITS) - 1;
  localparam logic [63:0] MEAN_LIMIT = (64'd1 << blw_pkg::MEAN_MAG_W) - 1;
  localparam logic [blw_pkg::CUT_W-1:0] CUT_ALL = 33'h1_0000_0000;
  localparam int MEAN_LSB = blw_pkg::JUMP_W;
  localparam int X_LSB = MEAN_LSB + blw_pkg::MEAN_W;
  localparam int Y_LSB = X_LSB + blw_pkg::X_W;
  localparam int Z_LSB = Y_LSB + blw_pkg::POS_W;
  localparam int PAD_LSB = Z_LSB + blw_pkg::POS_W;
  localparam int SETTLE_CYCLES = 128;
  localparam int DRAIN_CYCLES = 5000;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int REPORT_LINES = 40;
  localparam blw_pkg::cfg_reg_t CUT_REGS [5] = '{blw_pkg::REG_CUT_PLUS_X,
                                                 blw_pkg::REG_CUT_MINUS_X,
                                                 blw_pkg::REG_CUT_PLUS_Y,
                                                 blw_pkg::REG_CUT_MINUS_Y,
                                                 blw_pkg::REG_CUT_PLUS_Z};

  // One input item: a jump or a restart.
  typedef struct {
    logic        restart;
    logic [31:0] fraction;
    logic        is_last;
  } walk_step_t;

  // One measurement record as the block should emit it.
  typedef struct {
    logic [blw_pkg::JUMP_W-1:0] jumps;
    logic [blw_pkg::MEAN_W-1:0] mean;
    logic [blw_pkg::X_W-1:0]    x;
    logic [blw_pkg::POS_W-1:0]  y;
    logic [blw_pkg::POS_W-1:0]  z;
    logic                       is_final;
    logic                       last;
  } walk_record_t;

  // Stall patterns of the record receiver.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [blw_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [blw_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [blw_pkg::FRACTION_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [blw_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  // Predictor copy of the registers and of the walk.
  logic [blw_pkg::CUT_W-1:0] cut_at [5];
  logic [blw_pkg::REG_SIZE_W-1:0] width_reg, height_reg;
  logic [blw_pkg::INTERVAL_W-1:0] interval_reg;
  longint walk_x;
  int unsigned walk_y, walk_z;
  logic [63:0] walk_jumps;
  longint walk_x_sum;
  int unsigned walk_since_record;

  walk_step_t walk_steps [$];
  walk_record_t expected_records [$];
  walk_step_t step_on_bus;
  walk_record_t record_due;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned records_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_started = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int mode_left = 0;
  int unsigned pattern_step = 0;
  rx_mode_t rx_mode = RX_ALWAYS;

  biased_lattice_walk_with_running_mean #(
    .JUMP_COUNT_BITS   (JUMP_BITS),
    .SIZE_BITS         (SIZE_BITS_TB),
    .MEAN_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // A size register of zero stands for the full lattice of 2^SIZE_BITS sites.
  function automatic int unsigned lattice_size(input logic [blw_pkg::REG_SIZE_W-1:0] reg_value);
    return (reg_value == '0) ? (32'd1 << SIZE_BITS_TB) : 32'(reg_value);
  endfunction

  // Periodic step; a coordinate beyond a shrunken size is folded back here.
  function automatic int unsigned wrap_move(input int unsigned coord, input int unsigned size,
                                            input logic up);
    int unsigned v;
    v = up ? coord + size + 1 : coord + size - 1;
    return v % size;
  endfunction

  function automatic void recentre_walk();
    walk_x = 0;
    walk_y = lattice_size(width_reg) / 2;
    walk_z = lattice_size(height_reg) / 2;
    walk_jumps = '0;
    walk_x_sum = 0;
    walk_since_record = 0;
  endfunction

  // Mean of x in signed Q.16: magnitude divided, truncated toward zero, saturated.
  function automatic logic [blw_pkg::MEAN_W-1:0] mean_of_x();
    logic [63:0] mag, quo, rem, scaled;
    logic neg;
    neg = walk_x_sum < 0;
    mag = neg ? 64'd0 - walk_x_sum : walk_x_sum;
    quo = mag / walk_jumps;
    rem = mag % walk_jumps;
    if (quo > (MEAN_LIMIT >> FRAC_BITS)) scaled = MEAN_LIMIT;
    else scaled = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / walk_jumps);
    if (scaled > MEAN_LIMIT) scaled = MEAN_LIMIT;
    if (neg) scaled = 64'd0 - scaled;
    return scaled[blw_pkg::MEAN_W-1:0];
  endfunction

  // Apply one accepted item to the walk and queue the records it calls for.
  task automatic advance_walk(input walk_step_t step);
    logic [blw_pkg::CUT_W-1:0] r;
    logic signed [64:0] wide_sum;
    int unsigned every;
    logic due;
    walk_record_t rec;
    if (step.restart) begin
      recentre_walk();
      return;
    end
    // The first threshold that the fraction falls below picks the move.
    r = {1'b0, step.fraction};
    if (r < cut_at[0]) begin
      if (walk_x < X_LIMIT) walk_x++;
    end else if (r < cut_at[1]) begin
      if (walk_x > -X_LIMIT) walk_x--;
    end else if (r < cut_at[2]) begin
      walk_y = wrap_move(walk_y, lattice_size(width_reg), 1'b1);
    end else if (r < cut_at[3]) begin
      walk_y = wrap_move(walk_y, lattice_size(width_reg), 1'b0);
    end else if (r < cut_at[4]) begin
      walk_z = wrap_move(walk_z, lattice_size(height_reg), 1'b1);
    end else begin
      walk_z = wrap_move(walk_z, lattice_size(height_reg), 1'b0);
    end
    if (walk_jumps < X_LIMIT) walk_jumps++;
    // Sum of x saturates at the signed 64-bit limits.
    wide_sum = 65'(walk_x_sum);
    wide_sum = wide_sum + walk_x;
    if (wide_sum[64] != wide_sum[63]) begin
      walk_x_sum = wide_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      walk_x_sum = wide_sum[63:0];
    end
    // A zero interval behaves as one.
    every = (interval_reg == '0) ? 32'd1 : interval_reg;
    due = walk_since_record >= every - 1;
    if (due) walk_since_record = 0;
    else walk_since_record++;
    rec.jumps = walk_jumps[blw_pkg::JUMP_W-1:0];
    rec.mean = mean_of_x();
    rec.x = walk_x[blw_pkg::X_W-1:0];
    rec.y = walk_y[blw_pkg::POS_W-1:0];
    rec.z = walk_z[blw_pkg::POS_W-1:0];
    if (due) begin
      rec.is_final = 1'b0;
      rec.last = !step.is_last;
      expected_records.insert(expected_records.size(), rec);
    end
    if (step.is_last) begin
      rec.is_final = 1'b1;
      rec.last = 1'b1;
      expected_records.insert(expected_records.size(), rec);
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < REPORT_LINES) $display("cycle %0d: mismatch: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("record %0d %s is %0h, expected %0h",
                                records_seen, name, got, want));
    end
  endtask

  // Input driver: bursts of items with random gaps, holding an item until taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_walk(step_on_bus);
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (walk_steps.size() > 0) begin
          step_on_bus = walk_steps.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= step_on_bus.fraction;
          s_tuser <= step_on_bus.restart;
          s_tlast <= step_on_bus.is_last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls: a long hold on request, otherwise a changing pattern.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else if (holds_started != hold_requests) begin
      holds_started++;
      hold_left = LONG_HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 150);
      end else begin
        mode_left--;
      end
      pattern_step++;
      case (rx_mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
        default:   m_tready <= (pattern_step % 7) < 4;
      endcase
    end
  end

  // Record monitor: each record taken is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      records_seen++;
      if (expected_records.size() == 0) begin
        report_mismatch($sformatf("record %0d arrived with none expected", records_seen));
      end else begin
        record_due = expected_records.pop_front();
        check_field("jumps", 64'(m_tdata[blw_pkg::JUMP_W-1:0]), 64'(record_due.jumps));
        check_field("mean_x_q16", 64'(m_tdata[MEAN_LSB +: blw_pkg::MEAN_W]),
                    64'(record_due.mean));
        check_field("x", 64'(m_tdata[X_LSB +: blw_pkg::X_W]), 64'(record_due.x));
        check_field("y_position", 64'(m_tdata[Y_LSB +: blw_pkg::POS_W]), 64'(record_due.y));
        check_field("z_position", 64'(m_tdata[Z_LSB +: blw_pkg::POS_W]), 64'(record_due.z));
        check_field("padding", 64'(m_tdata[blw_pkg::OUT_DATA_W-1:PAD_LSB]), 64'd0);
        check_field("is_final", 64'(m_tuser), 64'(record_due.is_final));
        check_field("last_of_run", 64'(m_tlast), 64'(record_due.last));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("biased_lattice_walk_with_running_mean regression: fail");
    $finish;
  end

  task automatic queue_jump(input logic [31:0] fraction, input logic is_last);
    walk_step_t step;
    step.restart = 1'b0;
    step.fraction = fraction;
    step.is_last = is_last;
    walk_steps.insert(walk_steps.size(), step);
    items_queued++;
  endtask

  // Fraction and flag travel along but the block ignores them on a restart.
  task automatic queue_restart();
    walk_step_t step;
    step.restart = 1'b1;
    step.fraction = $urandom;
    step.is_last = 1'($urandom_range(0, 1));
    walk_steps.insert(walk_steps.size(), step);
    items_queued++;
  endtask

  // Register write; the predictor takes the value once the write is accepted.
  task automatic write_reg(input blw_pkg::cfg_reg_t reg_index,
                           input logic [blw_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (reg_index)
      blw_pkg::REG_CUT_PLUS_X:  cut_at[0] = value;
      blw_pkg::REG_CUT_MINUS_X: cut_at[1] = value;
      blw_pkg::REG_CUT_PLUS_Y:  cut_at[2] = value;
      blw_pkg::REG_CUT_MINUS_Y: cut_at[3] = value;
      blw_pkg::REG_CUT_PLUS_Z:  cut_at[4] = value;
      blw_pkg::REG_WIDTH_Y:     width_reg = value[blw_pkg::REG_SIZE_W-1:0];
      blw_pkg::REG_HEIGHT_Z:    height_reg = value[blw_pkg::REG_SIZE_W-1:0];
      default:                  interval_reg = value[blw_pkg::INTERVAL_W-1:0];
    endcase
  endtask

  // Wait until every item is taken and every record is in, or the drain limit is hit,
  // then let the divider and the remainder unit run out before touching the registers.
  task automatic wait_idle();
    int waited;
    while (items_accepted != items_queued) @(posedge clk);
    waited = 0;
    while (expected_records.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Size value: mostly small so that wraps are frequent, with junk above bit 15.
  function automatic logic [blw_pkg::CFG_DATA_W-1:0] random_size();
    logic [blw_pkg::CFG_DATA_W-1:0] value;
    int choice;
    choice = $urandom_range(0, 9);
    value = '0;
    if (choice == 0) value[15:0] = 16'd0;
    else if (choice == 1) value[15:0] = 16'hFFFF;
    else if (choice == 2) value[15:0] = 16'($urandom_range(1, 65535));
    else value[15:0] = 16'($urandom_range(1, 12));
    if ($urandom_range(0, 1) == 1) begin
      value[blw_pkg::CFG_DATA_W-1:16] = (blw_pkg::CFG_DATA_W-16)'($urandom);
    end
    return value;
  endfunction

  // New settings for one random phase; busy phases get a record on every jump.
  task automatic pick_settings(input logic busy);
    logic [blw_pkg::CUT_W-1:0] cut_list [$];
    logic [blw_pkg::CFG_DATA_W-1:0] value;
    int style;
    style = $urandom_range(0, 5);
    for (int i = 0; i < 5; i++) begin
      if (style == 5) value = ($urandom_range(0, 1) == 1) ? CUT_ALL : '0;
      else if ($urandom_range(0, 7) == 0) value = CUT_ALL;
      else value = {1'b0, $urandom};
      cut_list.insert(cut_list.size(), value);
    end
    // Mostly ordered thresholds; otherwise left in random order.
    if (style < 4) cut_list.sort();
    for (int i = 0; i < 5; i++) write_reg(CUT_REGS[i], cut_list[i]);
    write_reg(blw_pkg::REG_WIDTH_Y, random_size());
    write_reg(blw_pkg::REG_HEIGHT_Z, random_size());
    value = '0;
    style = $urandom_range(0, 9);
    if (busy) value[31:0] = 32'd1;
    else if (style == 0) value[31:0] = 32'd0;
    else if (style == 1) value[31:0] = 32'hFFFF_FFFF;
    else if (style == 2) value[31:0] = $urandom;
    else value[31:0] = $urandom_range(1, 30);
    value[32] = 1'($urandom_range(0, 1));
    write_reg(blw_pkg::REG_INTERVAL, value);
  endtask

  // Random fraction, now and then right on or just under a threshold.
  function automatic logic [31:0] pick_fraction();
    logic [blw_pkg::CUT_W-1:0] cut;
    if ($urandom_range(0, 7) == 0) begin
      cut = cut_at[$urandom_range(0, 4)];
      return cut[31:0] - $urandom_range(0, 1);
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    int count;
    int phase;
    int random_items;
    logic busy;
    cut_at[0] = blw_pkg::CUT_PLUS_X_RESET;
    cut_at[1] = blw_pkg::CUT_MINUS_X_RESET;
    cut_at[2] = blw_pkg::CUT_PLUS_Y_RESET;
    cut_at[3] = blw_pkg::CUT_MINUS_Y_RESET;
    cut_at[4] = blw_pkg::CUT_PLUS_Z_RESET;
    width_reg = blw_pkg::WIDTH_Y_RESET;
    height_reg = blw_pkg::HEIGHT_Z_RESET;
    interval_reg = blw_pkg::INTERVAL_RESET;
    recentre_walk();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: each move, both sides of a threshold, a final record,
    // the walk going on after it, and a restart.
    queue_jump(32'd0, 1'b0);
    queue_jump(blw_pkg::CUT_PLUS_X_RESET[31:0] - 32'd1, 1'b0);
    queue_jump(blw_pkg::CUT_PLUS_X_RESET[31:0], 1'b0);
    queue_jump(blw_pkg::CUT_MINUS_X_RESET[31:0], 1'b0);
    queue_jump(blw_pkg::CUT_PLUS_Y_RESET[31:0], 1'b0);
    queue_jump(blw_pkg::CUT_MINUS_Y_RESET[31:0], 1'b0);
    queue_jump(32'hFFFF_FFFF, 1'b0);
    queue_jump(blw_pkg::CUT_PLUS_Z_RESET[31:0], 1'b1);
    queue_jump(32'd0, 1'b0);
    queue_restart();
    queue_jump(32'd0, 1'b0);
    wait_idle();

    // Interval shortened mid-run; the second jump owes both records at once.
    write_reg(blw_pkg::REG_INTERVAL, 33'd3);
    queue_jump(blw_pkg::CUT_MINUS_X_RESET[31:0] - 32'd1, 1'b0);
    queue_jump(32'd0, 1'b1);
    wait_idle();

    // Sizes changed without a restart, a zero height and a zero interval.
    write_reg(blw_pkg::REG_WIDTH_Y, 33'd3);
    write_reg(blw_pkg::REG_HEIGHT_Z, 33'd0);
    write_reg(blw_pkg::REG_INTERVAL, 33'd0);
    queue_jump(blw_pkg::CUT_MINUS_X_RESET[31:0], 1'b0);
    queue_jump(32'hFFFF_FFFF, 1'b0);
    queue_restart();
    queue_jump(blw_pkg::CUT_PLUS_Y_RESET[31:0], 1'b0);
    queue_jump(blw_pkg::CUT_PLUS_Y_RESET[31:0], 1'b0);
    queue_jump(32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // Thresholds out of order and at both ends of their range.
    write_reg(blw_pkg::REG_CUT_PLUS_X, '0);
    write_reg(blw_pkg::REG_CUT_MINUS_X, CUT_ALL);
    write_reg(blw_pkg::REG_CUT_PLUS_Y, '0);
    write_reg(blw_pkg::REG_CUT_MINUS_Y, '0);
    write_reg(blw_pkg::REG_CUT_PLUS_Z, '0);
    write_reg(blw_pkg::REG_WIDTH_Y, 33'd1);
    write_reg(blw_pkg::REG_HEIGHT_Z, 33'd65535);
    write_reg(blw_pkg::REG_INTERVAL, 33'hFFFF_FFFF);
    queue_jump(32'hFFFF_FFFF, 1'b0);
    queue_jump(32'd0, 1'b1);
    wait_idle();
    write_reg(blw_pkg::REG_CUT_MINUS_X, '0);
    queue_restart();
    queue_jump(32'h8000_0000, 1'b1);
    wait_idle();

    // Random phases, each under fresh settings; two of them record every jump
    // while the receiver holds off for a long stretch.
    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      busy = (phase == 2) || (phase == 7);
      pick_settings(busy);
      if (busy) hold_requests++;
      count = $urandom_range(80, 140);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 49) == 0) queue_restart();
        else queue_jump(pick_fraction(), $urandom_range(0, 39) == 0);
      end
      random_items += count;
      wait_idle();
      phase++;
    end

    if (expected_records.size() != 0) begin
      report_mismatch($sformatf("%0d records never arrived", expected_records.size()));
    end
    if (mismatch_count == 0) begin
      $display("biased_lattice_walk_with_running_mean regression: pass");
    end else begin
      $display("biased_lattice_walk_with_running_mean regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/blw_pkg.sv
sv/blw_fifo.sv
sv/blw_front.sv
sv/blw_mean_div.sv
sv/blw_back.sv
sv/biased_lattice_walk_with_running_mean.sv
tb/sv/tb_top.sv
